>>> src/knn_topk_insertion_select_defines.svh
`ifndef KNN_TOPK_INSERTION_SELECT_DEFINES_SVH
`define KNN_TOPK_INSERTION_SELECT_DEFINES_SVH
// assertion helpers
`define KNN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: lbl");
`define KNN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: lbl");
`endif

>>> src/knn_pkg.sv
package knn_pkg;
    localparam int IdW   = 24;
    localparam int DistW = 39;

    typedef enum logic [1:0] {
        REQ_QUERY = 2'd0,
        REQ_CAND  = 2'd1,
        REQ_END   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  elem_pos;
        logic signed [15:0] elem_value;
        logic [23:0] cand_id;
        logic        last_elem;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  rank;
        logic [23:0] neighbor_id;
        logic [38:0] neighbor_dist;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [DistW-1:0] sq_dist;
        logic [IdW-1:0]   id;
    } entry_t;
endpackage

>>> src/knn_dist.sv
module knn_dist #(
    parameter int DIM = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_we,
    input  logic [6:0]           pos,
    input  logic signed [15:0]   value,
    input  logic                 cand_en,
    input  logic                 clr,
    output logic [38:0]          cand_dist
);
    import knn_pkg::*;
    localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;

    logic signed [15:0] qmem [DIM];
    logic signed [15:0] q_rd_reg;
    logic signed [15:0] v_reg;
    logic               d_vld_reg;
    logic               in_rng;
    logic [AW-1:0]      addr;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [33:0]        sq;
    logic [39:0]        sum;
    logic [38:0]        acc_reg, acc_next;
    logic               init_reg;
    logic [AW-1:0]      init_cnt_reg;

    assign in_rng = ({25'd0, pos} < DIM);
    assign addr   = AW'(pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg     <= 1'b1;
            init_cnt_reg <= '0;
        end else if (init_reg) begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if ({{(32-AW){1'b0}}, init_cnt_reg} == DIM - 1) init_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (init_reg) qmem[init_cnt_reg] <= '0;
        else if (q_we && in_rng) qmem[addr] <= value;
        q_rd_reg <= qmem[addr];
        v_reg    <= value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) d_vld_reg <= 1'b0;
        else d_vld_reg <= cand_en && in_rng;
    end

    assign diff = 17'(q_rd_reg) - 17'(v_reg);
    assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
    assign sq   = mag * mag;
    assign sum  = {1'b0, acc_reg} + {6'd0, sq};

    always_comb begin
        acc_next = acc_reg;
        if (d_vld_reg) acc_next = sum[39] ? '1 : sum[38:0];
        if (clr) acc_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) acc_reg <= '0;
        else acc_reg <= acc_next;
    end

    assign cand_dist = d_vld_reg ? (sum[39] ? '1 : sum[38:0]) : acc_reg;
endmodule

>>> src/knn_list.sv
module knn_list #(
    parameter int MAX_K = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [6:0]            k_eff,
    input  logic                  ins_go,
    input  knn_pkg::entry_t       ins_ent,
    input  logic                  emit_go,
    output logic                  busy,
    output logic                  o_valid,
    input  logic                  o_ready,
    output knn_pkg::out_item_t    o_item
);
    import knn_pkg::*;
    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CHK  = 6'b000010,
        ST_SRCH = 6'b000100,
        ST_SHFT = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_EWT  = 6'b100000
    } st_t;

    entry_t       lmem [MAX_K];
    entry_t       rd_reg;
    logic [AW-1:0] raddr;
    logic         we;
    logic [AW-1:0] waddr;
    entry_t       wdata;

    st_t          st_reg, st_next;
    logic [6:0]   fill_reg, fill_next;
    logic [6:0]   idx_reg, idx_next;
    logic [6:0]   n_reg, n_next;
    entry_t       new_reg, new_next;
    entry_t       carry_reg, carry_next;
    logic         placed_reg, placed_next;
    logic         rvld_reg, rvld_next;
    out_item_t    o_reg, o_next;
    logic         ov_reg, ov_next;
    logic [6:0]   fill_cut;

    assign fill_cut = (fill_reg > k_eff) ? k_eff : fill_reg;

    always_ff @(posedge aclk) begin
        if (we) lmem[waddr] <= wdata;
        rd_reg <= lmem[raddr];
    end

    always_comb begin
        st_next = st_reg; fill_next = fill_reg; idx_next = idx_reg; n_next = n_reg;
        new_next = new_reg; carry_next = carry_reg; placed_next = placed_reg;
        rvld_next = 1'b0; o_next = o_reg; ov_next = ov_reg;
        we = 1'b0; waddr = idx_reg[AW-1:0]; wdata = carry_reg;
        raddr = idx_reg[AW-1:0];
        if (ov_reg && o_ready) ov_next = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (ins_go) begin
                    new_next    = ins_ent;
                    idx_next    = '0;
                    placed_next = 1'b0;
                    n_next      = fill_cut;
                    fill_next   = fill_cut;
                    raddr       = '0;
                    rvld_next   = 1'b1;
                    st_next     = ST_SRCH;
                    if (fill_cut == 7'd0) begin
                        st_next = ST_SHFT;
                        rvld_next = 1'b0;
                    end else if (fill_cut == k_eff) begin
                        // full list: compare against the worst entry first
                        raddr = AW'(fill_cut - 7'd1);
                        rvld_next = 1'b0;
                        st_next = ST_CHK;
                    end
                end else if (emit_go) begin
                    n_next   = fill_cut;
                    idx_next = '0;
                    raddr    = '0;
                    fill_next = '0;
                    st_next  = ST_EMIT;
                end
            end
            ST_CHK: begin
                if (rd_reg.sq_dist <= new_reg.sq_dist) begin
                    st_next = ST_IDLE;
                end else begin
                    raddr = '0;
                    rvld_next = 1'b1;
                    st_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                // walk list; once new entry is placed, ripple carry down
                if (rvld_reg) begin
                    if (!placed_reg) begin
                        if (rd_reg.sq_dist >= new_reg.sq_dist) begin
                            we = 1'b1; wdata = new_reg;
                            placed_next = 1'b1; carry_next = rd_reg;
                        end
                    end else begin
                        we = 1'b1; wdata = carry_reg; carry_next = rd_reg;
                    end
                    if (idx_reg + 7'd1 == n_reg) begin
                        idx_next = n_reg; st_next = ST_SHFT;
                    end else begin
                        idx_next = idx_reg + 7'd1;
                        raddr = idx_next[AW-1:0];
                        rvld_next = 1'b1;
                    end
                end
            end
            ST_SHFT: begin
                // tail slot: append carry or new entry if room
                if (n_reg < k_eff) begin
                    we = 1'b1;
                    waddr = n_reg[AW-1:0];
                    wdata = placed_reg ? carry_reg : new_reg;
                    fill_next = n_reg + 7'd1;
                end
                st_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (!ov_reg || o_ready) st_next = ST_EWT;
                raddr = idx_reg[AW-1:0];
            end
            ST_EWT: begin
                ov_next = 1'b1;
                o_next.rank = idx_reg[5:0];
                if (n_reg == 7'd0) begin
                    o_next = '0; o_next.last = 1'b1;
                    st_next = ST_IDLE;
                end else begin
                    o_next.found = 1'b1;
                    o_next.neighbor_id = rd_reg.id;
                    o_next.neighbor_dist = rd_reg.sq_dist;
                    o_next.last = (idx_reg + 7'd1 == n_reg);
                    if (idx_reg + 7'd1 == n_reg) st_next = ST_IDLE;
                    else begin
                        idx_next = idx_reg + 7'd1;
                        raddr = idx_next[AW-1:0];
                        st_next = ST_EMIT;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; fill_reg <= '0; ov_reg <= 1'b0; rvld_reg <= 1'b0;
            placed_reg <= 1'b0; idx_reg <= '0; n_reg <= '0;
        end else begin
            st_reg <= st_next; fill_reg <= fill_next; ov_reg <= ov_next;
            rvld_reg <= rvld_next; placed_reg <= placed_next;
            idx_reg <= idx_next; n_reg <= n_next;
        end
        new_reg <= new_next; carry_reg <= carry_next; o_reg <= o_next;
    end

    assign busy    = (st_reg != ST_IDLE);
    assign o_valid = ov_reg;
    assign o_item  = o_reg;
endmodule

>>> src/knn_topk_insertion_select.sv
// Query and candidate component transfers: accepted back to back.
// Last component: insertion walks the list memory while the input stalls.
// End of set: the input stalls while the results are read out, and the read-out waits while
// the sink holds off; each result is read from the list memory into an output register.
// Reset: synchronous active low; a query memory clearing pass runs before the input is ready.
module knn_topk_insertion_select #(
    parameter int DIM   = 128,
    parameter int MAX_K = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  knn_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output knn_pkg::out_item_t  m_data
);
    import knn_pkg::*;

    logic [6:0]  k_reg;
    logic [6:0]  k_eff;
    logic        acc;
    logic        busy;
    logic        hold_reg;
    logic        init_reg;
    logic [10:0] init_cnt_reg;
    logic        ins_pend_reg, emit_pend_reg;
    logic [23:0] id_reg;
    logic [38:0] cand_dist;
    entry_t      ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) k_reg <= 7'd64;
        else if (cfg_we) k_reg <= cfg_wdata;
    end

    always_comb begin
        k_eff = k_reg;
        if (k_reg == 7'd0) k_eff = 7'd1;
        if ({25'd0, k_reg} > MAX_K) k_eff = 7'(MAX_K);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= 1'b1; init_cnt_reg <= '0;
        end else if (init_reg) begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if ({21'd0, init_cnt_reg} >= DIM) init_reg <= 1'b0;
        end
    end

    assign s_ready = !init_reg && !busy && !hold_reg && !ins_pend_reg && !emit_pend_reg;
    assign acc     = s_valid && s_ready;

    knn_dist #(.DIM(DIM)) u_dist (
        .aclk(aclk), .aresetn(aresetn),
        .q_we(acc && s_data.req_type == REQ_QUERY),
        .pos(s_data.elem_pos), .value(s_data.elem_value),
        .cand_en(acc && s_data.req_type == REQ_CAND),
        .clr(ins_pend_reg || (acc && s_data.req_type == REQ_END)),
        .cand_dist(cand_dist)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_pend_reg <= 1'b0; emit_pend_reg <= 1'b0; hold_reg <= 1'b0;
        end else begin
            ins_pend_reg  <= acc && s_data.req_type == REQ_CAND && s_data.last_elem;
            emit_pend_reg <= acc && s_data.req_type == REQ_END;
            hold_reg      <= ins_pend_reg || emit_pend_reg;
        end
        if (acc) id_reg <= s_data.cand_id;
    end

    assign ent.sq_dist = cand_dist;
    assign ent.id      = id_reg;

    knn_list #(.MAX_K(MAX_K)) u_list (
        .aclk(aclk), .aresetn(aresetn), .k_eff(k_eff),
        .ins_go(ins_pend_reg), .ins_ent(ent), .emit_go(emit_pend_reg),
        .busy(busy), .o_valid(m_valid), .o_ready(m_ready), .o_item(m_data)
    );
endmodule

>>> src/knn_chk.sv
`include "knn_topk_insertion_select_defines.svh"
module knn_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input knn_pkg::out_item_t m_data
);
    `KNN_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `KNN_ASSERT_IMP(a_empty_last, aclk, aresetn, m_valid && !m_data.found, m_data.last && m_data.rank == 6'd0)
    `KNN_ASSERT_NXT(a_emit_busy, aclk, aresetn, m_valid && m_ready && m_data.found && !m_data.last, !s_ready)
    `KNN_ASSERT_NXT(a_s_hold, aclk, aresetn, s_valid && !s_ready, s_valid)
endmodule

bind knn_topk_insertion_select knn_chk u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

>>> dv/knn_topk_insertion_select_test.sv
`timescale 1ns / 100ps

module knn_topk_insertion_select_test;
    import knn_pkg::*;

    localparam int DIM   = 128;
    localparam int MAX_K = 64;
    localparam logic [38:0] DIST_SAT = {39{1'b1}};

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    knn_topk_insertion_select #(.DIM(DIM), .MAX_K(MAX_K)) u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [15:0] query_vec [DIM];
    logic [38:0] acc_dist;
    logic [38:0] list_dist [MAX_K];
    logic [23:0] list_id [MAX_K];
    int          list_fill;
    logic [6:0]  k_reg;

    out_item_t neighbor_q[$];
    int  err_count = 0;
    int  result_count = 0;
    int  item_count = 0;
    int  cand_count = 0;
    bit  sink_hold = 1'b0;
    int  hold_cycles = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int active_k();
        int k;
        k = k_reg;
        if (k == 0) k = 1;
        if (k > MAX_K) k = MAX_K;
        return k;
    endfunction

    function automatic void rank_insert(input logic [38:0] d, input logic [23:0] id);
        int k;
        int p;
        k = active_k();
        p = 0;
        if (list_fill > k) list_fill = k;
        if (list_fill == k) begin
            if (d >= list_dist[k-1]) return;
        end else begin
            list_fill++;
        end
        while (p < list_fill - 1 && list_dist[p] < d) p++;
        for (int i = list_fill - 1; i > p; i--) begin
            list_dist[i] = list_dist[i-1];
            list_id[i] = list_id[i-1];
        end
        list_dist[p] = d;
        list_id[p] = id;
    endfunction

    function automatic void predict_neighbors(input in_item_t it);
        int n;
        logic signed [17:0] diff;
        logic [39:0] sq;
        logic [40:0] sum;
        out_item_t r;
        case (it.req_type)
            REQ_QUERY: begin
                if (it.elem_pos < DIM) query_vec[it.elem_pos] = it.elem_value;
            end
            REQ_CAND: begin
                if (it.elem_pos < DIM) begin
                    diff = 18'(query_vec[it.elem_pos]) - 18'(it.elem_value);
                    if (diff < 0) diff = -diff;
                    sq = 40'(diff) * 40'(diff);
                    sum = 41'(acc_dist) + 41'(sq);
                    acc_dist = (sum > 41'(DIST_SAT)) ? DIST_SAT : sum[38:0];
                end
                if (it.last_elem) begin
                    rank_insert(acc_dist, it.cand_id);
                    acc_dist = '0;
                end
            end
            REQ_END: begin
                n = (list_fill < active_k()) ? list_fill : active_k();
                acc_dist = '0;
                list_fill = 0;
                if (n == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    neighbor_q.push_back(r);
                end
                for (int i = 0; i < n; i++) begin
                    r.found = 1'b1;
                    r.rank = 6'(i);
                    r.neighbor_id = list_id[i];
                    r.neighbor_dist = list_dist[i];
                    r.last = (i + 1 == n);
                    neighbor_q.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // random sender gap: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays up after a transfer; the next call drops it for a gap, or an idle task drops it
    task automatic send_item(input in_item_t it);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_neighbors(it);
        item_count++;
        if (it.req_type == REQ_CAND && it.last_elem) cand_count++;
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        while (neighbor_q.size() != 0) @(posedge aclk);
        repeat (MAX_K + 10) @(posedge aclk);
    endtask

    // k changes only once the block is idle
    task automatic write_k(input logic [6:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        k_reg = v;
    endtask

    function automatic in_item_t mk(input req_t rq, input int pos, input int val,
                                    input int id, input bit lst);
        in_item_t it;
        it.req_type = rq;
        it.elem_pos = 7'(pos);
        it.elem_value = 16'(val);
        it.cand_id = 24'(id);
        it.last_elem = lst;
        return it;
    endfunction

    // short candidates over the first few positions
    task automatic send_candidate(input int dims, input int id, input bit wide);
        int v;
        for (int p = 0; p < dims; p++) begin
            v = wide ? $urandom_range(0, 65535) : $urandom_range(0, 15) - 8;
            send_item(mk(REQ_CAND, p, v, id, p == dims - 1));
        end
    endtask

    // sink: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && sink_hold) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 300) sink_hold <= 1'b0;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_item_t w;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (neighbor_q.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(m_data), 64'(0));
            end else begin
                w = neighbor_q.pop_front();
                if (m_data.found !== w.found)
                    report_mismatch("found", 64'(m_data.found), 64'(w.found));
                if (m_data.rank !== w.rank)
                    report_mismatch("rank", 64'(m_data.rank), 64'(w.rank));
                if (m_data.neighbor_id !== w.neighbor_id)
                    report_mismatch("neighbor_id", 64'(m_data.neighbor_id),
                                    64'(w.neighbor_id));
                if (m_data.neighbor_dist !== w.neighbor_dist)
                    report_mismatch("neighbor_dist", 64'(m_data.neighbor_dist),
                                    64'(w.neighbor_dist));
                if (m_data.last !== w.last)
                    report_mismatch("last", 64'(m_data.last), 64'(w.last));
            end
        end
    end

    typedef struct {
        in_item_t    it;
        bit          has_exp;
        out_item_t   exp_out;
    } stim_row_t;

    initial begin
        #20ms;
        $display("knn_topk_insertion_select test failed");
        $finish;
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        out_item_t empty_res;
        int n_sets;
        int dims;
        int r;

        for (int i = 0; i < DIM; i++) query_vec[i] = '0;
        for (int i = 0; i < MAX_K; i++) begin
            list_dist[i] = '0;
            list_id[i] = '0;
        end
        acc_dist = '0;
        list_fill = 0;
        k_reg = 7'd64;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        empty_res = '0;
        empty_res.last = 1'b1;
        row.has_exp = 1'b0;
        row.exp_out = '0;
        // empty set after reset
        row.it = mk(REQ_END, 0, 0, 0, 0); row.has_exp = 1; row.exp_out = empty_res;
        rows.push_back(row);
        row.has_exp = 0;
        // zero query vs zero candidate: distance 0, id max
        row.it = mk(REQ_CAND, 0, 0, 24'hFFFFFF, 1); rows.push_back(row);
        row.it = mk(REQ_END, 0, 0, 0, 0); row.has_exp = 1;
        row.exp_out = '{found: 1, rank: 0, neighbor_id: 24'hFFFFFF, neighbor_dist: 0, last: 1};
        rows.push_back(row);
        row.has_exp = 0;
        // extremes: query -32768, candidate 32767 -> 65535^2 per component
        row.it = mk(REQ_QUERY, 0, -32768, 0, 0); rows.push_back(row);
        row.it = mk(REQ_QUERY, 1, 32767, 0, 0); rows.push_back(row);
        row.it = mk(REQ_QUERY, 127, 5, 0, 0); rows.push_back(row);
        row.it = mk(REQ_CAND, 0, 32767, 1, 1); rows.push_back(row);
        row.it = mk(REQ_END, 0, 0, 0, 0); row.has_exp = 1;
        row.exp_out = '{found: 1, rank: 0, neighbor_id: 1, neighbor_dist: 39'd4294836225,
                        last: 1};
        rows.push_back(row);
        row.has_exp = 0;
        // ties, the last position, unknown request, end mid-candidate
        row.it = mk(REQ_CAND, 1, 32767, 2, 1); rows.push_back(row);
        row.it = mk(REQ_CAND, 127, 5, 3, 1); rows.push_back(row);
        row.it = mk(REQ_CAND, 1, 0, 4, 0); rows.push_back(row);
        row.it = mk(REQ_NONE, 1, 0, 4, 1); rows.push_back(row);
        row.it = mk(REQ_END, 0, 0, 0, 0); rows.push_back(row);
        row.it = mk(REQ_CAND, 1, -32768, 5, 0); rows.push_back(row);
        row.it = mk(REQ_CAND, 0, 32767, 6, 1); rows.push_back(row);
        row.it = mk(REQ_CAND, 1, -1, 7, 1); rows.push_back(row);
        row.it = mk(REQ_END, 0, 0, 0, 0); rows.push_back(row);
        row.it = mk(REQ_CAND, 1, 0, 8, 1); rows.push_back(row);
        row.it = mk(REQ_END, 0, 0, 0, 0); rows.push_back(row);

        foreach (rows[i]) begin
            send_item(rows[i].it);
            if (rows[i].has_exp) begin
                if (neighbor_q.size() == 0 || neighbor_q[$] !== rows[i].exp_out)
                    report_mismatch("directed row", 64'(i), 64'(0));
            end
        end
        drain_and_idle();

        for (int p = 0; p < 8; p++) send_item(mk(REQ_QUERY, p, $urandom_range(0, 15) - 8, 0, 0));

        // random sets across k settings; k rewritten to a small value mid-set in some
        n_sets = 0;
        while (item_count < 120) begin
            case (n_sets % 5)
                0: write_k(7'd1);
                1: write_k(7'd64);
                2: write_k(7'(($urandom_range(0, 1)) ? 0 : 127));
                default: write_k(7'($urandom_range(2, 12)));
            endcase
            r = (n_sets % 7 == 1) ? 16 : $urandom_range(0, 14);
            for (int c = 0; c < r; c++) begin
                dims = $urandom_range(1, 4);
                if ($urandom_range(0, 9) == 0)
                    send_item(mk(REQ_CAND, $urandom_range(0, 127),
                                 $urandom_range(0, 65535), $urandom, 1));
                else if ($urandom_range(0, 19) == 0)
                    send_item(mk(REQ_QUERY, $urandom_range(0, 127),
                                 $urandom_range(0, 65535), 0, 0));
                else if ($urandom_range(0, 29) == 0)
                    send_item(mk(REQ_NONE, $urandom_range(0, 127),
                                 $urandom_range(0, 65535), $urandom, $urandom_range(0, 1)));
                else
                    send_candidate(dims, $urandom_range(0, 24'hFFFFFF),
                                   $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 3) == 0 && r > 0) begin
                write_k(7'($urandom_range(1, 3)));
            end
            if (n_sets == 3) begin
                hold_cycles = 0;
                sink_hold = 1'b1;
            end
            send_item(mk(REQ_END, 0, 0, 0, 0));
            if (n_sets == 3) begin
                // keep offering while the results sit blocked
                for (int q = 0; q < 4; q++)
                    send_item(mk(REQ_QUERY, q, $urandom_range(0, 15) - 8, 0, 0));
            end
            drain_and_idle();
            n_sets++;
        end

        $display("covered %0d transfers in, %0d candidates, %0d results, %0d sets",
                 item_count, cand_count, result_count, n_sets);
        $display("k swept over small, full and out-of-range values, with mid-set reductions");
        if (err_count == 0 && neighbor_q.size() == 0) begin
            $display("knn_topk_insertion_select test passed");
        end else begin
            $display("knn_topk_insertion_select test failed");
        end
        $finish;
    end
endmodule
